### hdl/mskt_pkg.sv
// Shared types and constants for the multi-set k-th smallest threshold block.
package mskt_pkg;

  localparam int DATA_W  = 32;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 5;
  localparam int SET_W   = 4;

  localparam logic [CFG_IW-1:0] REG_ACTIVE_SETS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_KEEP_RANK   = 2'd1;

  localparam logic [4:0] ACTIVE_SETS_RST = 5'd16;
  localparam logic [3:0] KEEP_RANK_RST   = 4'd0;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Operand pairs for the shared greater-than unit
  typedef enum logic [2:0] {
    CMP_V_BEST,   // value  > threshold
    CMP_V_RD,     // value  > read data
    CMP_R_L,      // right  > left child
    CMP_B_V,      // bigger > value
    CMP_BEST_RD   // threshold > root
  } cmp_sel_t;

endpackage

### hdl/mskt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mskt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/mskt_cmp.sv
// Shared signed greater-than unit with operand selection.
module mskt_cmp (
  input  mskt_pkg::cmp_sel_t                  sel,
  input  logic signed [mskt_pkg::DATA_W-1:0]  value,
  input  logic signed [mskt_pkg::DATA_W-1:0]  best,
  input  logic signed [mskt_pkg::DATA_W-1:0]  rdata,
  input  logic signed [mskt_pkg::DATA_W-1:0]  lval,
  input  logic signed [mskt_pkg::DATA_W-1:0]  bval,
  output logic                                gt
);

  logic signed [mskt_pkg::DATA_W-1:0] op_a;
  logic signed [mskt_pkg::DATA_W-1:0] op_b;

  always_comb begin
    case (sel)
      mskt_pkg::CMP_V_BEST: begin
        op_a = value;
        op_b = best;
      end
      mskt_pkg::CMP_V_RD: begin
        op_a = value;
        op_b = rdata;
      end
      mskt_pkg::CMP_R_L: begin
        op_a = rdata;
        op_b = lval;
      end
      mskt_pkg::CMP_B_V: begin
        op_a = bval;
        op_b = value;
      end
      mskt_pkg::CMP_BEST_RD: begin
        op_a = best;
        op_b = rdata;
      end
      default: begin
        op_a = value;
        op_b = best;
      end
    endcase
  end

  assign gt = op_a > op_b;

endmodule

### hdl/multi_set_kth_smallest_threshold_core.sv
// Top level: bounded max-heap per set, tracking the least root of all full heaps.
//
// Usage:
//   Input channel (in_valid/in_ready): in_kind 0 adds in_value to set in_set_index,
//   in_kind 1 empties every heap. Exactly one result item follows each input item
//   on the out_ channel: the current threshold, its valid flag and a set error flag.
//   Configuration (cfg_we/cfg_index/cfg_data): index 0 is active_sets, index 1 is
//   keep_rank. A write to either register also empties all heaps. Write only while idle.
// Sequencing:
//   One item at a time; in_ready is high only in the idle state. Clear, error and
//   dropped items go from dispatch straight to the final state. An insert reads
//   the parent at each heap level of sift-up; a replace reads, per level of sift-down,
//   the left child, then the right one if present, with up to two passes through the
//   shared comparator. A replace, and an insert that fills its heap, then re-read the root.
//   The single read port of the heap RAM and the one shared comparator set the pace.
// Reset:
//   rst_n low (synchronous) empties all heaps, invalidates the threshold and
//   loads active_sets 16, keep_rank 0. The heap RAM needs no clearing pass.
// Stall:
//   A result waits in the output register while the next item is worked on; that
//   item then holds in the final state until the receiver takes the waiting one.
module multi_set_kth_smallest_threshold_core #(
  parameter int MAX_SETS = 16,
  parameter int MAX_KEEP = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [mskt_pkg::SET_W-1:0]          in_set_index,
  input  logic signed [mskt_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mskt_pkg::DATA_W-1:0]  out_threshold,
  output logic                                out_threshold_valid,
  output logic                                out_set_error,
  input  logic                                cfg_we,
  input  logic [mskt_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [mskt_pkg::CFG_DW-1:0]         cfg_data
);

  // Only sets reachable through the 4-bit index get storage
  localparam int USED_SETS = (MAX_SETS < 16) ? MAX_SETS : 16;
  localparam int DEPTH     = USED_SETS * MAX_KEEP;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW        = $clog2(2 * MAX_KEEP + 2);
  localparam int FW        = $clog2(MAX_KEEP + 1);
  localparam int SIW       = (USED_SETS > 1) ? $clog2(USED_SETS) : 1;
  localparam int DW        = mskt_pkg::DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SU_STEP,
    ST_SU_CMP,
    ST_SD_STEP,
    ST_SD_LEFT,
    ST_SD_RIGHT,
    ST_SD_CMP,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic                  kind_r, kind_nxt;
  logic [mskt_pkg::SET_W-1:0] set_r, set_nxt;
  logic signed [DW-1:0]  value_r, value_nxt;
  logic [AW-1:0]         base_r, base_nxt;
  logic [LW-1:0]         loc_r, loc_nxt;
  logic [LW-1:0]         big_r, big_nxt;
  logic signed [DW-1:0]  lval_r, lval_nxt;
  logic signed [DW-1:0]  bval_r, bval_nxt;
  logic                  note_r, note_nxt;
  logic                  err_r, err_nxt;
  logic [FW-1:0]         fill_r [USED_SETS];
  logic [FW-1:0]         fill_nxt [USED_SETS];
  logic signed [DW-1:0]  best_r, best_nxt;
  logic                  known_r, known_nxt;
  logic [4:0]            active_sets_r, active_sets_nxt;
  logic [3:0]            keep_rank_r, keep_rank_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]  out_thr_r, out_thr_nxt;
  logic                  out_thv_r, out_thv_nxt;
  logic                  out_err_r, out_err_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic signed [DW-1:0]  ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic signed [DW-1:0]  ram_rdata;

  mskt_pkg::cmp_sel_t    cmp_sel;
  logic                  cmp_gt;

  logic [SIW-1:0]        set_idx;
  logic [FW-1:0]         fill_cur;
  logic [4:0]            kr1;
  logic [LW-1:0]         cap;
  logic [LW-1:0]         left;
  logic [LW-1:0]         right;
  logic                  set_oob;
  logic                  out_free;

  mskt_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mskt_cmp u_cmp (
    .sel   (cmp_sel),
    .value (value_r),
    .best  (best_r),
    .rdata (ram_rdata),
    .lval  (lval_r),
    .bval  (bval_r),
    .gt    (cmp_gt)
  );

  function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] base,
                                              input logic [LW-1:0] loc);
    logic [LW-1:0] off;
    off = loc - LW'(1);
    return base + AW'(off);
  endfunction

  assign set_idx  = set_r[SIW-1:0];
  assign fill_cur = fill_r[set_idx];
  assign kr1      = {1'b0, keep_rank_r} + 5'd1;
  // Heap capacity: keep_rank + 1, capped at MAX_KEEP
  assign cap      = (32'(kr1) > MAX_KEEP) ? LW'(MAX_KEEP) : LW'(kr1);
  assign left     = loc_r << 1;
  assign right    = left + LW'(1);
  assign set_oob  = ({1'b0, set_r} >= active_sets_r) ||
                    (32'(set_r) >= MAX_SETS);
  assign out_free = !out_valid_r || out_ready;

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_threshold       = out_thr_r;
  assign out_threshold_valid = out_thv_r;
  assign out_set_error       = out_err_r;

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    set_nxt         = set_r;
    value_nxt       = value_r;
    base_nxt        = base_r;
    loc_nxt         = loc_r;
    big_nxt         = big_r;
    lval_nxt        = lval_r;
    bval_nxt        = bval_r;
    note_nxt        = note_r;
    err_nxt         = err_r;
    fill_nxt        = fill_r;
    best_nxt        = best_r;
    known_nxt       = known_r;
    active_sets_nxt = active_sets_r;
    keep_rank_nxt   = keep_rank_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_thr_nxt     = out_thr_r;
    out_thv_nxt     = out_thv_r;
    out_err_nxt     = out_err_r;
    ram_we          = 1'b0;
    ram_waddr       = slot_addr(base_r, loc_r);
    ram_wdata       = value_r;
    ram_raddr       = slot_addr(base_r, LW'(1));
    cmp_sel         = mskt_pkg::CMP_V_BEST;

    // Writes to either register re-initialize every heap
    if (cfg_we) begin
      case (cfg_index)
        mskt_pkg::REG_ACTIVE_SETS: begin
          active_sets_nxt = cfg_data[4:0];
          for (int i = 0; i < USED_SETS; i++) fill_nxt[i] = '0;
          best_nxt  = '0;
          known_nxt = 1'b0;
        end
        mskt_pkg::REG_KEEP_RANK: begin
          keep_rank_nxt = cfg_data[3:0];
          for (int i = 0; i < USED_SETS; i++) fill_nxt[i] = '0;
          best_nxt  = '0;
          known_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          set_nxt   = in_set_index;
          value_nxt = in_value;
          base_nxt  = AW'(32'(in_set_index[SIW-1:0]) * MAX_KEEP);
          err_nxt   = 1'b0;
          note_nxt  = 1'b0;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmp_sel = mskt_pkg::CMP_V_BEST;
        if (kind_r == mskt_pkg::KIND_CLEAR) begin
          for (int i = 0; i < USED_SETS; i++) fill_nxt[i] = '0;
          best_nxt  = '0;
          known_nxt = 1'b0;
          state_nxt = ST_FINISH;
        end else if (set_oob) begin
          err_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else if (known_r && cmp_gt) begin
          // drop values above the threshold
          state_nxt = ST_FINISH;
        end else if (LW'(fill_cur) >= cap) begin
          loc_nxt   = LW'(1);
          note_nxt  = 1'b1;
          state_nxt = ST_SD_STEP;
        end else begin
          fill_nxt[set_idx] = fill_cur + FW'(1);
          loc_nxt   = LW'(fill_cur) + LW'(1);
          note_nxt  = ((LW'(fill_cur) + LW'(1)) == cap);
          state_nxt = ST_SU_STEP;
        end
      end
      // Sift-up: the hole at loc_r moves toward the root
      ST_SU_STEP: begin
        if (loc_r == LW'(1)) begin
          ram_we    = 1'b1;
          state_nxt = note_r ? ST_ROOT_RD : ST_FINISH;
        end else begin
          ram_raddr = slot_addr(base_r, loc_r >> 1);
          state_nxt = ST_SU_CMP;
        end
      end
      ST_SU_CMP: begin
        cmp_sel = mskt_pkg::CMP_V_RD;
        ram_we  = 1'b1;
        if (cmp_gt) begin
          ram_wdata = ram_rdata;
          loc_nxt   = loc_r >> 1;
          state_nxt = ST_SU_STEP;
        end else begin
          state_nxt = note_r ? ST_ROOT_RD : ST_FINISH;
        end
      end
      // Sift-down: the hole at loc_r moves toward the leaves
      ST_SD_STEP: begin
        if (left > cap) begin
          ram_we    = 1'b1;
          state_nxt = ST_ROOT_RD;
        end else begin
          ram_raddr = slot_addr(base_r, left);
          state_nxt = ST_SD_LEFT;
        end
      end
      ST_SD_LEFT: begin
        lval_nxt = ram_rdata;
        if (right <= cap) begin
          ram_raddr = slot_addr(base_r, right);
          state_nxt = ST_SD_RIGHT;
        end else begin
          big_nxt   = left;
          bval_nxt  = ram_rdata;
          state_nxt = ST_SD_CMP;
        end
      end
      ST_SD_RIGHT: begin
        cmp_sel = mskt_pkg::CMP_R_L;
        if (cmp_gt) begin
          big_nxt  = right;
          bval_nxt = ram_rdata;
        end else begin
          big_nxt  = left;
          bval_nxt = lval_r;
        end
        state_nxt = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        cmp_sel = mskt_pkg::CMP_B_V;
        ram_we  = 1'b1;
        if (cmp_gt) begin
          ram_wdata = bval_r;
          loc_nxt   = big_r;
          state_nxt = ST_SD_STEP;
        end else begin
          state_nxt = ST_ROOT_RD;
        end
      end
      ST_ROOT_RD: begin
        ram_raddr = slot_addr(base_r, LW'(1));
        state_nxt = ST_ROOT_CMP;
      end
      ST_ROOT_CMP: begin
        cmp_sel = mskt_pkg::CMP_BEST_RD;
        if (!known_r || cmp_gt) begin
          best_nxt  = ram_rdata;
          known_nxt = 1'b1;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_thr_nxt   = known_r ? best_r : '0;
          out_thv_nxt   = known_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < USED_SETS; i++) fill_r[i] <= '0;
      best_r        <= '0;
      known_r       <= 1'b0;
      active_sets_r <= mskt_pkg::ACTIVE_SETS_RST;
      keep_rank_r   <= mskt_pkg::KEEP_RANK_RST;
      note_r        <= 1'b0;
      err_r         <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      fill_r        <= fill_nxt;
      best_r        <= best_nxt;
      known_r       <= known_nxt;
      active_sets_r <= active_sets_nxt;
      keep_rank_r   <= keep_rank_nxt;
      note_r        <= note_nxt;
      err_r         <= err_nxt;
    end
    kind_r    <= kind_nxt;
    set_r     <= set_nxt;
    value_r   <= value_nxt;
    base_r    <= base_nxt;
    loc_r     <= loc_nxt;
    big_r     <= big_nxt;
    lval_r    <= lval_nxt;
    bval_r    <= bval_nxt;
    out_thr_r <= out_thr_nxt;
    out_thv_r <= out_thv_nxt;
    out_err_r <= out_err_nxt;
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_FINISH || state_r == ST_DISPATCH) |-> !ram_we)
    else $error("heap RAM written outside a sift");

  a_loc_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SU_STEP || state_r == ST_SU_CMP || state_r == ST_SD_STEP ||
     state_r == ST_SD_CMP) |-> (loc_r != '0 && loc_r <= cap))
    else $error("sift position outside the heap");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result issued without finishing an item");

  a_unknown_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !known_r |-> (best_r == '0))
    else $error("threshold register nonzero while invalid");
`endif

endmodule

### tb/mskt_threshold_checker.sv
`timescale 1ns / 1ps
// Checker for the threshold core: predicts each result item and compares it.
module mskt_threshold_checker #(
  parameter int MAX_SETS = 16,
  parameter int MAX_KEEP = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_kind,
  input  logic [mskt_pkg::SET_W-1:0]          in_set_index,
  input  logic signed [mskt_pkg::DATA_W-1:0]  in_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [mskt_pkg::DATA_W-1:0]  out_threshold,
  input  logic                                out_threshold_valid,
  input  logic                                out_set_error,
  input  logic                                cfg_we,
  input  logic [mskt_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [mskt_pkg::CFG_DW-1:0]         cfg_data,
  output int                                  fail_count,
  output int                                  results_checked,
  output int                                  outstanding
);

  typedef struct packed {
    logic [mskt_pkg::DATA_W-1:0] threshold;
    logic                        threshold_valid;
    logic                        set_error;
  } threshold_result_t;

  logic signed [mskt_pkg::DATA_W-1:0] heap_slot [MAX_SETS][MAX_KEEP];
  logic [4:0]                         heap_fill [MAX_SETS];
  logic signed [mskt_pkg::DATA_W-1:0] least_root;
  logic                               root_known;
  logic [4:0]                         sets_setting;
  logic [3:0]                         rank_setting;

  threshold_result_t threshold_queue [$];

  initial begin
    fail_count      = 0;
    results_checked = 0;
    outstanding     = 0;
  end

  function automatic void empty_heaps();
    for (int s = 0; s < MAX_SETS; s++) heap_fill[s] = '0;
    least_root = '0;
    root_known = 1'b0;
  endfunction

  function automatic void note_root(logic signed [mskt_pkg::DATA_W-1:0] root);
    if (!root_known || root < least_root) begin
      least_root = root;
      root_known = 1'b1;
    end
  endfunction

  // Heap positions are 1-based, as in the usual array heap layout.
  function automatic void admit_value(int s, logic signed [mskt_pkg::DATA_W-1:0] v);
    int cap;
    int loc;
    int left;
    int big;
    int parent;
    logic signed [mskt_pkg::DATA_W-1:0] t;
    cap = int'(rank_setting) + 1;
    if (cap > MAX_KEEP) cap = MAX_KEEP;
    if (root_known && v > least_root) return;
    if (int'(heap_fill[s]) >= cap) begin
      loc = 1;
      heap_slot[s][0] = v;
      forever begin
        left = loc * 2;
        if (left > cap) break;
        big = left;
        if (left + 1 <= cap && heap_slot[s][left] > heap_slot[s][left-1]) big = left + 1;
        if (heap_slot[s][big-1] > heap_slot[s][loc-1]) begin
          t = heap_slot[s][big-1];
          heap_slot[s][big-1] = heap_slot[s][loc-1];
          heap_slot[s][loc-1] = t;
          loc = big;
        end else begin
          break;
        end
      end
      note_root(heap_slot[s][0]);
    end else begin
      heap_fill[s] = heap_fill[s] + 5'd1;
      loc = int'(heap_fill[s]);
      heap_slot[s][loc-1] = v;
      while (loc != 1) begin
        parent = loc / 2;
        if (heap_slot[s][loc-1] > heap_slot[s][parent-1]) begin
          t = heap_slot[s][parent-1];
          heap_slot[s][parent-1] = heap_slot[s][loc-1];
          heap_slot[s][loc-1] = t;
          loc = parent;
        end else begin
          break;
        end
      end
      if (int'(heap_fill[s]) == cap) note_root(heap_slot[s][0]);
    end
  endfunction

  function automatic threshold_result_t predict_threshold(
      logic kind, logic [mskt_pkg::SET_W-1:0] s, logic signed [mskt_pkg::DATA_W-1:0] v);
    threshold_result_t r;
    int limit;
    r.set_error = 1'b0;
    limit = (int'(sets_setting) > MAX_SETS) ? MAX_SETS : int'(sets_setting);
    if (kind == mskt_pkg::KIND_CLEAR) begin
      empty_heaps();
    end else if (int'(s) >= limit) begin
      r.set_error = 1'b1;
    end else begin
      admit_value(int'(s), v);
    end
    r.threshold       = root_known ? least_root : '0;
    r.threshold_valid = root_known;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    threshold_result_t due;
    if (!rst_n) begin
      sets_setting = mskt_pkg::ACTIVE_SETS_RST;
      rank_setting = mskt_pkg::KEEP_RANK_RST;
      empty_heaps();
      threshold_queue.delete();
    end else begin
      // a write to an unmapped index leaves the heaps alone
      if (cfg_we) begin
        if (cfg_index == mskt_pkg::REG_ACTIVE_SETS) begin
          sets_setting = cfg_data;
          empty_heaps();
        end else if (cfg_index == mskt_pkg::REG_KEEP_RANK) begin
          rank_setting = cfg_data[3:0];
          empty_heaps();
        end
      end
      if (out_valid && out_ready) begin
        if (threshold_queue.size() == 0) begin
          $error("result item with nothing expected: threshold %0d valid %0b error %0b",
                 out_threshold, out_threshold_valid, out_set_error);
          fail_count++;
        end else begin
          due = threshold_queue.pop_front();
          results_checked++;
          if (out_threshold !== due.threshold) begin
            $error("threshold: expected %0d, got %0d", $signed(due.threshold), out_threshold);
            fail_count++;
          end
          if (out_threshold_valid !== due.threshold_valid) begin
            $error("threshold_valid: expected %0b, got %0b", due.threshold_valid,
                   out_threshold_valid);
            fail_count++;
          end
          if (out_set_error !== due.set_error) begin
            $error("set_error: expected %0b, got %0b", due.set_error, out_set_error);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        threshold_queue.push_back(predict_threshold(in_kind, in_set_index, in_value));
    end
    outstanding <= threshold_queue.size();
  end

endmodule

### tb/tb_multi_set_kth_smallest_threshold_core.sv
`timescale 1ns / 1ps
// Testbench top: drives items and register writes into the threshold core and gives the verdict.
module tb_multi_set_kth_smallest_threshold_core;

  localparam int SETS          = 16;
  localparam int KEEP          = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 170;
  localparam int SW            = mskt_pkg::SET_W;
  localparam int DW            = mskt_pkg::DATA_W;
  localparam int CIW           = mskt_pkg::CFG_IW;
  localparam int CDW           = mskt_pkg::CFG_DW;

  // Index 3 maps to no register; a write there must not clear anything.
  localparam logic [CIW-1:0] REG_SPARE = 2'd3;

  localparam logic signed [DW-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] VALUE_MIN = 32'sh8000_0000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_kind = mskt_pkg::KIND_ADD;
  logic [SW-1:0]             in_set_index = '0;
  logic signed [DW-1:0]      in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DW-1:0]      out_threshold;
  logic                      out_threshold_valid;
  logic                      out_set_error;
  logic                      cfg_we = 1'b0;
  logic [CIW-1:0]            cfg_index = '0;
  logic [CDW-1:0]            cfg_data = '0;

  int fail_count;
  int results_checked;
  int outstanding;

  int         idle_pct = 12;       // chance in a hundred that a side idles in a cycle
  int         cycle_count = 0;
  int         items_sent = 0;
  int         reg_writes = 0;
  logic [4:0] active_now = mskt_pkg::ACTIVE_SETS_RST;   // stimulus copy of active_sets

  multi_set_kth_smallest_threshold_core #(
    .MAX_SETS (SETS),
    .MAX_KEEP (KEEP)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_set_index        (in_set_index),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_threshold       (out_threshold),
    .out_threshold_valid (out_threshold_valid),
    .out_set_error       (out_set_error),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  mskt_threshold_checker #(
    .MAX_SETS (SETS),
    .MAX_KEEP (KEEP)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_set_index        (in_set_index),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_threshold       (out_threshold),
    .out_threshold_valid (out_threshold_valid),
    .out_set_error       (out_set_error),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .results_checked     (results_checked),
    .outstanding         (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random, or never while idle_pct is zero.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Sets the block actually uses: active_sets capped at the heap count.
  function automatic int usable_sets();
    return (int'(active_now) > SETS) ? SETS : int'(active_now);
  endfunction

  // Mostly a narrow window so heaps fill and replace often, with ties and full-range values.
  function automatic logic [DW-1:0] pick_value();
    int            roll;
    logic [DW-1:0] r;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      r = $urandom();
    end else if (roll < 45) begin
      r = $urandom_range(0, 40);
      r = r - 32'd20;
    end else begin
      r = $urandom_range(0, 4000);
      r = r - 32'd2000;
    end
    return r;
  endfunction

  // Present one item from a falling edge and hold it until the block takes it.
  // Valid is left high on return; the next call or settle() decides what follows.
  task automatic offer_item(input logic kind, input logic [SW-1:0] set_idx,
                            input logic [DW-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_set_index <= set_idx;
    in_value     <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and hold off until every expected result is back and the block is idle.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || !in_ready);
  endtask

  // One-cycle write strobe; call only after settle().
  task automatic write_register(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mskt_pkg::REG_ACTIVE_SETS) active_now = data;
    reg_writes++;
  endtask

  // Random item: mostly well-formed adds into live sets, some clears and out-of-range sets.
  task automatic random_item();
    int            roll;
    int            usable;
    logic [SW-1:0] set_idx;
    roll   = $urandom_range(0, 99);
    usable = usable_sets();
    if (roll < 3) begin
      set_idx = SW'($urandom_range(0, SETS - 1));
      offer_item(mskt_pkg::KIND_CLEAR, set_idx, $urandom());
    end else if (roll < 9 || usable == 0) begin
      // out of range where the setting leaves room for it, else a full-range add
      if (usable < SETS) set_idx = SW'($urandom_range(usable, SETS - 1));
      else set_idx = SW'($urandom_range(0, SETS - 1));
      offer_item(mskt_pkg::KIND_ADD, set_idx, $urandom());
    end else begin
      set_idx = SW'($urandom_range(0, usable - 1));
      offer_item(mskt_pkg::KIND_ADD, set_idx, pick_value());
    end
  endtask

  initial begin
    int         item_total;
    logic [4:0] sets_pick;
    logic [4:0] rank_pick;

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, one slot per heap across all sixteen sets.
    offer_item(mskt_pkg::KIND_ADD, 4'd0, VALUE_MAX);   // first full heap: threshold at the top
    offer_item(mskt_pkg::KIND_ADD, 4'd15, VALUE_MIN);  // threshold falls to the bottom value
    offer_item(mskt_pkg::KIND_ADD, 4'd3, 32'sd5);      // above threshold: drop
    offer_item(mskt_pkg::KIND_ADD, 4'd4, VALUE_MIN);   // equal to threshold: keep
    offer_item(mskt_pkg::KIND_CLEAR, 4'd15, -32'sd1);  // clear ignores set and value

    // Four sets of four slots: out-of-range sets, sift-up and sift-down.
    settle();
    write_register(mskt_pkg::REG_ACTIVE_SETS, 5'd4);
    write_register(mskt_pkg::REG_KEEP_RANK, 5'd3);
    offer_item(mskt_pkg::KIND_ADD, 4'd4, 32'sd7);
    offer_item(mskt_pkg::KIND_ADD, 4'd15, -32'sd1);
    offer_item(mskt_pkg::KIND_ADD, 4'd1, 32'sd10);
    offer_item(mskt_pkg::KIND_ADD, 4'd1, 32'sd30);
    offer_item(mskt_pkg::KIND_ADD, 4'd1, 32'sd20);
    offer_item(mskt_pkg::KIND_ADD, 4'd1, 32'sd40);     // heap fills, root 40
    offer_item(mskt_pkg::KIND_ADD, 4'd1, 32'sd25);     // replace root and sift down
    offer_item(mskt_pkg::KIND_ADD, 4'd1, 32'sd30);     // tie with threshold
    offer_item(mskt_pkg::KIND_ADD, 4'd1, 32'sd31);     // drop
    offer_item(mskt_pkg::KIND_ADD, 4'd0, -32'sd5);

    // No sets at all: every add is an error.
    settle();
    write_register(mskt_pkg::REG_ACTIVE_SETS, 5'd0);
    offer_item(mskt_pkg::KIND_ADD, 4'd0, 32'sd1);
    offer_item(mskt_pkg::KIND_CLEAR, 4'd0, 32'sd0);

    // Set count above the heap count, then an unmapped write that must keep the heaps.
    settle();
    write_register(mskt_pkg::REG_ACTIVE_SETS, 5'd31);
    write_register(mskt_pkg::REG_KEEP_RANK, 5'd0);
    offer_item(mskt_pkg::KIND_ADD, 4'd15, 32'sd100);
    settle();
    write_register(REG_SPARE, 5'h1F);
    offer_item(mskt_pkg::KIND_ADD, 4'd14, 32'sd200);   // still dropped against 100

    // Random phases, each under fresh settings; extremes come first.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      // phases 3 and 4 run with no idling on either side
      idle_pct = (p == 3 || p == 4) ? 0 : 12;
      case (p)
        0: begin
          sets_pick = 5'd16;
          rank_pick = 5'd15;
        end
        1: begin
          sets_pick = 5'd1;
          rank_pick = 5'd0;
        end
        2: begin
          sets_pick = 5'd31;
          rank_pick = 5'h1F;                   // top data bit lies beyond the register
        end
        3: begin
          sets_pick = 5'd0;
          rank_pick = 5'd7;
        end
        default: begin
          if ($urandom_range(0, 99) < 80) sets_pick = 5'($urandom_range(1, SETS));
          else sets_pick = 5'($urandom_range(0, 31));
          rank_pick = 5'($urandom_range(0, 31));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_register(mskt_pkg::REG_ACTIVE_SETS, sets_pick);
        write_register(mskt_pkg::REG_KEEP_RANK, rank_pick);
      end else begin
        write_register(mskt_pkg::REG_KEEP_RANK, rank_pick);
        write_register(mskt_pkg::REG_ACTIVE_SETS, sets_pick);
      end
      if ($urandom_range(0, 2) == 0) write_register(REG_SPARE, CDW'($urandom_range(0, 31)));

      item_total = (usable_sets() == 0) ? 20 : PHASE_ITEMS;
      for (int i = 0; i < item_total; i++) begin
        // halfway through, starve the block until it has answered everything
        if (i == item_total / 2) settle();
        random_item();
      end
    end

    settle();
    idle_pct = 12;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items under %0d register writes, across varied set and rank counts",
             items_sent, reg_writes);
    $display("%0d results compared, with fills, replaces, drops, ties, clears and bad sets",
             results_checked);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
